[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/lrmf_pkg.sv]
// ----------------------------------------------------------------------------
// lrmf_pkg
// Types, register indexes and helpers of the lane row midpoint finder.
// ----------------------------------------------------------------------------
package lrmf_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam logic [11:0] C_MAX_W = 12'(MAX_WIDTH);
    localparam logic [11:0] C_MAX_H = 12'(MAX_HEIGHT);

    // Configuration register indexes
    localparam logic [2:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_EDGE_MARGIN  = 3'd2;
    localparam logic [2:0] CFG_BOTTOM_SKIP  = 3'd3;
    localparam logic [2:0] CFG_MIN_GAP      = 3'd4;
    localparam logic [2:0] CFG_WHITE_LEVEL  = 3'd5;

    // Reset values
    localparam logic [11:0] RST_FRAME_WIDTH  = 12'd640;
    localparam logic [11:0] RST_FRAME_HEIGHT = 12'd480;
    localparam logic [7:0]  RST_EDGE_MARGIN  = 8'd20;
    localparam logic [10:0] RST_BOTTOM_SKIP  = 11'd100;
    localparam logic [10:0] RST_MIN_GAP      = 11'd100;
    localparam logic [7:0]  RST_WHITE_LEVEL  = 8'd255;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic       frame_start;
    } t_in_req;

    typedef struct packed {
        logic [10:0] goal_x;
        logic [10:0] goal_y;
        logic        goal_valid;
        logic [10:0] align_start_x;
        logic [10:0] align_start_y;
        logic        align_start_valid;
        logic [10:0] align_end_x;
        logic [10:0] align_end_y;
        logic        align_end_valid;
    } t_out_req;

    typedef struct packed {
        logic [10:0] x;
        logic [10:0] y;
        logic        valid;
    } t_point;

    localparam t_point POINT_NONE = '{x: 11'd0, y: 11'd0, valid: 1'b0};

    // Zero acts as one, anything above the maximum acts as the maximum.
    function automatic logic [11:0] clamp_size(input logic [11:0] v, input logic [11:0] maxv);
        logic [11:0] r;
        if (v == 12'd0) begin
            r = 12'd1;
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

[src/lane_row_midpoint_finder.sv]
// Result path: the result of a frame is valid on o_out_req once its last pixel
//   request has passed the input register and then the result register.
// Throughput: one pixel per clock; the per-row edge search runs on running
//   registers only, so the only stall comes from a held result.
// Reset: synchronous active low; clears counters, edges, points and handshake
//   state and loads the configuration registers with their default values.
// ----------------------------------------------------------------------------
// lane_row_midpoint_finder
// Scans a raster lane mask for the outer white pixels of each row and reports
// goal, align start and align end midpoints once per frame.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lane_row_midpoint_finder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_index,
    input  logic [11:0]        i_cfg_data,
    // pixel requests
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lrmf_pkg::t_in_req  i_in_req,
    // frame results
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lrmf_pkg::t_out_req o_out_req
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [11:0] r_frame_width;
    logic [11:0] r_frame_height;
    logic [7:0]  r_edge_margin;
    logic [10:0] r_bottom_skip;
    logic [10:0] r_min_gap;
    logic [7:0]  r_white_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= lrmf_pkg::RST_FRAME_WIDTH;
            r_frame_height <= lrmf_pkg::RST_FRAME_HEIGHT;
            r_edge_margin  <= lrmf_pkg::RST_EDGE_MARGIN;
            r_bottom_skip  <= lrmf_pkg::RST_BOTTOM_SKIP;
            r_min_gap      <= lrmf_pkg::RST_MIN_GAP;
            r_white_level  <= lrmf_pkg::RST_WHITE_LEVEL;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                lrmf_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                lrmf_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                lrmf_pkg::CFG_EDGE_MARGIN:  r_edge_margin  <= i_cfg_data[7:0];
                lrmf_pkg::CFG_BOTTOM_SKIP:  r_bottom_skip  <= i_cfg_data[10:0];
                lrmf_pkg::CFG_MIN_GAP:      r_min_gap      <= i_cfg_data[10:0];
                lrmf_pkg::CFG_WHITE_LEVEL:  r_white_level  <= i_cfg_data[7:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: input register feeds the row logic, result register
    // holds a frame result until the sink takes it.
    // ------------------------------------------------------------------
    logic               r_in_valid;
    lrmf_pkg::t_in_req  r_in;
    logic               r_out_valid;
    lrmf_pkg::t_out_req r_out;

    logic w_fire;        // the held pixel is processed this cycle
    logic w_frame_end;   // the held pixel closes the frame
    logic w_out_free;    // result register can take a new result
    logic w_in_accept;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    // Hold the pixel only when it would produce a result that has no room.
    assign w_fire      = r_in_valid && (!w_frame_end || w_out_free);
    assign o_in_stall  = r_in_valid && !w_fire;
    assign w_in_accept = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    // ------------------------------------------------------------------
    // Running row state
    // ------------------------------------------------------------------
    logic [10:0]      r_col;
    logic [10:0]      r_row;
    logic [10:0]      r_left;
    logic             r_left_seen;
    logic [10:0]      r_right;
    logic             r_right_seen;
    lrmf_pkg::t_point r_goal;
    lrmf_pkg::t_point r_start;
    lrmf_pkg::t_point r_end;

    // state seen by this pixel after a frame start clears it
    logic [10:0]      s_col;
    logic [10:0]      s_row;
    logic [10:0]      s_left;
    logic             s_left_seen;
    logic [10:0]      s_right;
    logic             s_right_seen;
    lrmf_pkg::t_point s_goal;
    lrmf_pkg::t_point s_start;
    lrmf_pkg::t_point s_end;

    logic [11:0]      w_width;
    logic [11:0]      w_height;
    logic             w_white;
    logic             w_left_hit;
    logic             w_right_hit;
    logic             w_row_end;
    logic             w_row_counts;
    logic [11:0]      w_sum;
    logic [10:0]      w_gap;
    lrmf_pkg::t_point w_point;

    logic [10:0]      n_left;
    logic             n_left_seen;
    logic [10:0]      n_right;
    logic             n_right_seen;
    lrmf_pkg::t_point n_goal;
    lrmf_pkg::t_point n_start;
    lrmf_pkg::t_point n_end;

    always_comb begin
        w_width  = lrmf_pkg::clamp_size(r_frame_width, lrmf_pkg::C_MAX_W);
        w_height = lrmf_pkg::clamp_size(r_frame_height, lrmf_pkg::C_MAX_H);

        // A frame start wipes the frame before this pixel is looked at.
        if (r_in.frame_start) begin
            s_col        = 11'd0;
            s_row        = 11'd0;
            s_left       = 11'd0;
            s_left_seen  = 1'b0;
            s_right      = 11'd0;
            s_right_seen = 1'b0;
            s_goal       = lrmf_pkg::POINT_NONE;
            s_start      = lrmf_pkg::POINT_NONE;
            s_end        = lrmf_pkg::POINT_NONE;
        end else begin
            s_col        = r_col;
            s_row        = r_row;
            s_left       = r_left;
            s_left_seen  = r_left_seen;
            s_right      = r_right;
            s_right_seen = r_right_seen;
            s_goal       = r_goal;
            s_start      = r_start;
            s_end        = r_end;
        end

        w_white = (r_in.pixel_value == r_white_level);

        // Keep the first white pixel past the left margin, and the last one
        // short of the right margin.
        w_left_hit  = w_white && !s_left_seen && ({1'b0, s_col} >= {4'd0, r_edge_margin});
        w_right_hit = w_white && (({1'b0, s_col} + {4'd0, r_edge_margin}) <= w_width);

        n_left       = w_left_hit ? s_col : s_left;
        n_left_seen  = s_left_seen || w_left_hit;
        n_right      = w_right_hit ? s_col : s_right;
        n_right_seen = s_right_seen || w_right_hit;

        w_row_end   = ({1'b0, s_col} >= (w_width - 12'd1));
        w_frame_end = w_row_end && ({1'b0, s_row} >= (w_height - 12'd1));

        w_row_counts = w_row_end && n_left_seen && n_right_seen &&
                       (({1'b0, s_row} + {1'b0, r_bottom_skip}) <= w_height);

        w_sum = {1'b0, n_left} + {1'b0, n_right};
        w_gap = (n_left > n_right) ? (n_left - n_right) : (n_right - n_left);

        w_point.x     = w_sum[11:1];
        w_point.y     = s_row;
        w_point.valid = 1'b1;

        // Later rows lie lower, so the last counting row wins start, and the last
        // one past the gap test wins goal; end keeps the first one.
        n_start = w_row_counts ? w_point : s_start;
        n_end   = (w_row_counts && !s_end.valid) ? w_point : s_end;
        n_goal  = (w_row_counts && (w_gap > r_min_gap)) ? w_point : s_goal;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_col        <= 11'd0;
            r_row        <= 11'd0;
            r_left       <= 11'd0;
            r_left_seen  <= 1'b0;
            r_right      <= 11'd0;
            r_right_seen <= 1'b0;
            r_goal       <= lrmf_pkg::POINT_NONE;
            r_start      <= lrmf_pkg::POINT_NONE;
            r_end        <= lrmf_pkg::POINT_NONE;
        end else begin
            // input register
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end

            // result register
            if (w_fire && w_frame_end) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            // row state
            if (w_fire) begin
                if (w_row_end) begin
                    r_col        <= 11'd0;
                    r_left       <= 11'd0;
                    r_left_seen  <= 1'b0;
                    r_right      <= 11'd0;
                    r_right_seen <= 1'b0;
                    if (w_frame_end) begin
                        r_row   <= 11'd0;
                        r_goal  <= lrmf_pkg::POINT_NONE;
                        r_start <= lrmf_pkg::POINT_NONE;
                        r_end   <= lrmf_pkg::POINT_NONE;
                    end else begin
                        r_row   <= s_row + 11'd1;
                        r_goal  <= n_goal;
                        r_start <= n_start;
                        r_end   <= n_end;
                    end
                end else begin
                    r_col        <= s_col + 11'd1;
                    r_row        <= s_row;
                    r_left       <= n_left;
                    r_left_seen  <= n_left_seen;
                    r_right      <= n_right;
                    r_right_seen <= n_right_seen;
                    r_goal       <= s_goal;
                    r_start      <= s_start;
                    r_end        <= s_end;
                end
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in <= i_in_req;
        end
        if (w_fire && w_frame_end) begin
            // missing points are held at zero, so copy fields as they are
            r_out.goal_x            <= n_goal.x;
            r_out.goal_y            <= n_goal.y;
            r_out.goal_valid        <= n_goal.valid;
            r_out.align_start_x     <= n_start.x;
            r_out.align_start_y     <= n_start.y;
            r_out.align_start_valid <= n_start.valid;
            r_out.align_end_x       <= n_end.x;
            r_out.align_end_y       <= n_end.y;
            r_out.align_end_valid   <= n_end.valid;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A closing pixel always lands in the result register.
    `ASSERT_NEXT(a_result_loaded, w_fire && w_frame_end, o_out_valid)
    // Start and end come from the same set of counting rows.
    `ASSERT_IMPL(a_align_pair, o_out_valid,
                 o_out_req.align_start_valid == o_out_req.align_end_valid)
    // A goal row is a counting row too.
    `ASSERT_IMPL(a_goal_in_rows, o_out_valid && o_out_req.goal_valid,
                 o_out_req.align_start_valid)
    // A missing goal reports zero coordinates.
    `ASSERT_IMPL(a_goal_zero, o_out_valid && !o_out_req.goal_valid,
                 (o_out_req.goal_x == 11'd0) && (o_out_req.goal_y == 11'd0))

endmodule

[dv/lrmf_frame_checker.sv]
// ----------------------------------------------------------------------------
// lrmf_frame_checker
// Watches the pixel, result and register ports of the lane row midpoint
// finder. It predicts each frame result and compares it field by field.
// ----------------------------------------------------------------------------
module lrmf_frame_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_index,
    input  logic [11:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  lrmf_pkg::t_in_req  i_in_req,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  lrmf_pkg::t_out_req i_out_req,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_results_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the register file
    logic [11:0] width_reg  = lrmf_pkg::RST_FRAME_WIDTH;
    logic [11:0] height_reg = lrmf_pkg::RST_FRAME_HEIGHT;
    logic [7:0]  margin_reg = lrmf_pkg::RST_EDGE_MARGIN;
    logic [10:0] skip_reg   = lrmf_pkg::RST_BOTTOM_SKIP;
    logic [10:0] gap_reg    = lrmf_pkg::RST_MIN_GAP;
    logic [7:0]  white_reg  = lrmf_pkg::RST_WHITE_LEVEL;

    // Raster position and per-row edge search
    logic [10:0]      col_cnt   = '0;
    logic [10:0]      row_cnt   = '0;
    logic [10:0]      left_x    = '0;
    logic [10:0]      right_x   = '0;
    logic             left_hit  = 1'b0;
    logic             right_hit = 1'b0;
    lrmf_pkg::t_point goal_pt   = '0;
    lrmf_pkg::t_point start_pt  = '0;
    lrmf_pkg::t_point end_pt    = '0;

    lrmf_pkg::t_out_req frame_results_q[$];
    int                 fail_cnt = 0;
    int                 seen_cnt = 0;

    function automatic int unsigned fit_dim(input logic [11:0] v, input int unsigned maxv);
        if (v == 12'd0) begin
            return 1;
        end
        return (v > maxv) ? maxv : v;
    endfunction

    // A point without its valid bit reports zero coordinates.
    function automatic lrmf_pkg::t_point point_or_zero(input lrmf_pkg::t_point p);
        return p.valid ? p : lrmf_pkg::t_point'('0);
    endfunction

    function automatic string fmt_result(input lrmf_pkg::t_out_req r);
        return $sformatf("goal %0d,%0d,%0b start %0d,%0d,%0b end %0d,%0d,%0b",
                         r.goal_x, r.goal_y, r.goal_valid,
                         r.align_start_x, r.align_start_y, r.align_start_valid,
                         r.align_end_x, r.align_end_y, r.align_end_valid);
    endfunction

    task automatic clear_edges();
        left_x    = '0;
        left_hit  = 1'b0;
        right_x   = '0;
        right_hit = 1'b0;
    endtask

    task automatic clear_points();
        goal_pt  = '0;
        start_pt = '0;
        end_pt   = '0;
    endtask

    task automatic scan_pixel(input lrmf_pkg::t_in_req px);
        int unsigned        w, h, x, y, mid, span;
        lrmf_pkg::t_point   row_pt;
        lrmf_pkg::t_point   gp, sp, ep;
        lrmf_pkg::t_out_req res;
        w = fit_dim(width_reg, lrmf_pkg::MAX_WIDTH);
        h = fit_dim(height_reg, lrmf_pkg::MAX_HEIGHT);
        if (px.frame_start) begin
            col_cnt = '0;
            row_cnt = '0;
            clear_edges();
            clear_points();
        end
        x = col_cnt;
        y = row_cnt;
        if (px.pixel_value == white_reg) begin
            if (!left_hit && x >= margin_reg) begin
                left_x   = x[10:0];
                left_hit = 1'b1;
            end
            if (x + margin_reg <= w) begin
                right_x   = x[10:0];
                right_hit = 1'b1;
            end
        end
        if (x >= w - 1) begin
            if (left_hit && right_hit && y + skip_reg <= h) begin
                mid = (left_x + right_x) >> 1;
                span = (left_x > right_x) ? left_x - right_x : right_x - left_x;
                row_pt.x     = mid[10:0];
                row_pt.y     = y[10:0];
                row_pt.valid = 1'b1;
                // rows arrive top first, so the last counting row is the lowest
                start_pt = row_pt;
                if (!end_pt.valid) begin
                    end_pt = row_pt;
                end
                if (span > gap_reg) begin
                    goal_pt = row_pt;
                end
            end
            clear_edges();
            col_cnt = '0;
            if (y >= h - 1) begin
                gp = point_or_zero(goal_pt);
                sp = point_or_zero(start_pt);
                ep = point_or_zero(end_pt);
                res.goal_x            = gp.x;
                res.goal_y            = gp.y;
                res.goal_valid        = gp.valid;
                res.align_start_x     = sp.x;
                res.align_start_y     = sp.y;
                res.align_start_valid = sp.valid;
                res.align_end_x       = ep.x;
                res.align_end_y       = ep.y;
                res.align_end_valid   = ep.valid;
                frame_results_q.push_back(res);
                clear_points();
                row_cnt = '0;
            end else begin
                row_cnt = 11'(y + 1);
            end
        end else begin
            col_cnt = 11'(x + 1);
        end
    endtask

    task automatic check_result(input lrmf_pkg::t_out_req got);
        lrmf_pkg::t_out_req want;
        logic               bad;
        if (frame_results_q.size() == 0) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
                $display("%0t: frame result with none pending: %s", $realtime, fmt_result(got));
            end
        end else begin
            want = frame_results_q.pop_front();
            seen_cnt++;
            bad = (got.goal_x !== want.goal_x) || (got.goal_y !== want.goal_y)
               || (got.goal_valid !== want.goal_valid)
               || (got.align_start_x !== want.align_start_x)
               || (got.align_start_y !== want.align_start_y)
               || (got.align_start_valid !== want.align_start_valid)
               || (got.align_end_x !== want.align_end_x)
               || (got.align_end_y !== want.align_end_y)
               || (got.align_end_valid !== want.align_end_valid);
            if (bad) begin
                fail_cnt++;
                if (fail_cnt <= 10) begin
                    $display("%0t: frame result %0d mismatch", $realtime, seen_cnt);
                    $display("  expected %s", fmt_result(want));
                    $display("  actual   %s", fmt_result(got));
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = lrmf_pkg::RST_FRAME_WIDTH;
            height_reg = lrmf_pkg::RST_FRAME_HEIGHT;
            margin_reg = lrmf_pkg::RST_EDGE_MARGIN;
            skip_reg   = lrmf_pkg::RST_BOTTOM_SKIP;
            gap_reg    = lrmf_pkg::RST_MIN_GAP;
            white_reg  = lrmf_pkg::RST_WHITE_LEVEL;
            col_cnt    = '0;
            row_cnt    = '0;
            clear_edges();
            clear_points();
            frame_results_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    lrmf_pkg::CFG_FRAME_WIDTH:  width_reg  = i_cfg_data;
                    lrmf_pkg::CFG_FRAME_HEIGHT: height_reg = i_cfg_data;
                    lrmf_pkg::CFG_EDGE_MARGIN:  margin_reg = i_cfg_data[7:0];
                    lrmf_pkg::CFG_BOTTOM_SKIP:  skip_reg   = i_cfg_data[10:0];
                    lrmf_pkg::CFG_MIN_GAP:      gap_reg    = i_cfg_data[10:0];
                    lrmf_pkg::CFG_WHITE_LEVEL:  white_reg  = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                scan_pixel(i_in_req);
            end
            if (i_out_valid && !i_out_stall) begin
                check_result(i_out_req);
            end
        end
        o_fail_count   <= fail_cnt;
        o_pending      <= frame_results_q.size();
        o_results_seen <= seen_cnt;
    end

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives raster pixel requests and register writes into the lane row
// midpoint finder, stalls its result port at random, and leaves prediction
// and comparison to the frame checker beside it.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 250;
    localparam int ITEM_TARGET  = 1500;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [2:0]         cfg_index = lrmf_pkg::CFG_FRAME_WIDTH;
    logic [11:0]        cfg_data  = '0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    lrmf_pkg::t_in_req  in_req    = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    lrmf_pkg::t_out_req out_req;

    int          fail_count;
    int          pending;
    int          results_seen;

    // Stimulus bookkeeping
    int          items_sent   = 0;
    int          cycle_count  = 0;
    bit          calm         = 1'b0;
    bit          hold_trigger = 1'b0;
    bit          aligned      = 1'b0;
    int unsigned cur_w        = 1;
    int unsigned cur_h        = 1;
    logic [7:0]  cur_white    = lrmf_pkg::RST_WHITE_LEVEL;

    lane_row_midpoint_finder dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_req   (out_req)
    );

    lrmf_frame_checker frame_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_req       (in_req),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_req      (out_req),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: stall at random with a 14 percent chance, never while calm.
    // On request, hold the port off for a long fixed stretch so that the
    // block backs up and stalls its pixel input.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_trigger) begin
                hold_trigger = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= (!calm && $urandom_range(99) < 14);
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // Zero acts as one, anything past the maximum as the maximum.
    function automatic int unsigned fit_dim(input logic [11:0] v, input int unsigned maxv);
        if (v == 12'd0) begin
            return 1;
        end
        return (v > maxv) ? maxv : v;
    endfunction

    // Lane pixel with probability dens percent, otherwise any byte.
    function automatic logic [7:0] pick_pixel(input int dens, input logic [7:0] wl);
        return ($urandom_range(99) < dens) ? wl : 8'($urandom_range(255));
    endfunction

    // Offer one pixel request and hold it until the block takes it.
    task automatic send_pixel(input logic [7:0] pix, input logic fs);
        lrmf_pkg::t_in_req r;
        r.pixel_value = pix;
        r.frame_start = fs;
        if (!calm) begin
            while ($urandom_range(99) < 14) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_req   <= r;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    // n copies of one pixel, frame start on the first.
    task automatic send_run(input int n, input logic [7:0] pix);
        for (int i = 0; i < n; i++) begin
            send_pixel(pix, i == 0);
        end
    endtask

    // n random pixels; later pixels raise frame start with fs_pct percent.
    task automatic send_frame(input int unsigned n, input logic fs_first, input int fs_pct);
        int dens;
        case ($urandom_range(4))
            0:       dens = 0;
            1:       dens = 5;
            2:       dens = 20;
            3:       dens = 50;
            default: dens = 90;
        endcase
        for (int unsigned i = 0; i < n; i++) begin
            send_pixel(pick_pixel(dens, cur_white),
                       (i == 0) ? fs_first : ($urandom_range(99) < fs_pct));
        end
    endtask

    // Drop valid, drain every pending frame result, then let the two-stage
    // pipeline settle so a register write cannot race a pixel in flight.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [11:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Write the whole register file; only called with the block idle.
    task automatic program_regs(input logic [11:0] w, input logic [11:0] h,
                                input logic [7:0] m, input logic [10:0] bs,
                                input logic [10:0] gap, input logic [7:0] wl);
        write_reg(lrmf_pkg::CFG_FRAME_WIDTH, w);
        write_reg(lrmf_pkg::CFG_FRAME_HEIGHT, h);
        write_reg(lrmf_pkg::CFG_EDGE_MARGIN, m);
        write_reg(lrmf_pkg::CFG_BOTTOM_SKIP, bs);
        write_reg(lrmf_pkg::CFG_MIN_GAP, gap);
        write_reg(lrmf_pkg::CFG_WHITE_LEVEL, wl);
        cfg_wr_en <= 1'b0;
        cur_w     = fit_dim(w, lrmf_pkg::MAX_WIDTH);
        cur_h     = fit_dim(h, lrmf_pkg::MAX_HEIGHT);
        cur_white = wl;
    endtask

    // One random configuration followed by a few frames. Mostly whole,
    // well-formed frames; the rest are cut short or broken by stray starts.
    task automatic random_phase();
        logic [11:0] w, h;
        logic [7:0]  m, wl;
        logic [10:0] bs, gap;
        int unsigned ew, eh, lim_w, lim_h, frames;
        w = ($urandom_range(19) == 0) ? 12'd0 : 12'($urandom_range(1, 24));
        h = ($urandom_range(19) == 0) ? 12'd0 : 12'($urandom_range(1, 10));
        frames = $urandom_range(1, 4);
        ew    = fit_dim(w, lrmf_pkg::MAX_WIDTH);
        eh    = fit_dim(h, lrmf_pkg::MAX_HEIGHT);
        lim_w = (ew > 2047) ? 2047 : ew;
        lim_h = (eh > 2047) ? 2047 : eh;

        // margin: usually inside the row, sometimes past it
        case ($urandom_range(4))
            0, 1, 2: m = 8'($urandom_range(0, (ew > 255) ? 127 : ew / 2));
            3:       m = 8'($urandom_range(0, (ew + 2 > 255) ? 255 : ew + 2));
            default: m = $urandom_range(1) ? 8'd255 : 8'($urandom_range(255));
        endcase
        case ($urandom_range(9))
            0, 1, 2, 3, 4: bs = 11'($urandom_range(0, lim_h));
            5, 6, 7:       bs = 11'd0;
            default:       bs = 11'($urandom_range(0, 2047));
        endcase
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: gap = 11'($urandom_range(0, lim_w));
            6, 7:             gap = 11'd0;
            default:          gap = 11'($urandom_range(0, 2047));
        endcase
        case ($urandom_range(9))
            0, 1, 2, 3: wl = 8'd255;
            4, 5:       wl = 8'd0;
            default:    wl = 8'($urandom_range(255));
        endcase

        // one long stretch with no idling on either side
        calm = (items_sent >= 700 && items_sent < 1000);
        program_regs(w, h, m, bs, gap, wl);
        repeat (frames) begin
            if ($urandom_range(99) < 85) begin
                // after a clean frame end the block restarts on its own
                send_frame(cur_w * cur_h, aligned ? 1'($urandom_range(1)) : 1'b1, 0);
                aligned = 1'b1;
            end else begin
                send_frame($urandom_range(1, cur_w * cur_h + 3), 1'($urandom_range(1)), 3);
                aligned = 1'b0;
            end
        end
        wait_idle();
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero sizes act as a single pixel: one frame per request, with
        // and without a lane pixel, so missing points report zero.
        program_regs(12'd0, 12'd0, 8'd0, 11'd0, 11'd0, 8'd255);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd0, 1'b0);
        wait_idle();

        // 4x2 with white level zero: wide pair on the top row passes the
        // gap test, a single pixel on the bottom row does not.
        program_regs(12'd4, 12'd2, 8'd0, 11'd0, 11'd0, 8'd0);
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd7, 1'b0);
        send_pixel(8'd7, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd7, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd7, 1'b0);
        send_pixel(8'd7, 1'b0);
        wait_idle();

        // margin wider than the row: no edges anywhere
        program_regs(12'd4, 12'd1, 8'd255, 11'd0, 11'd0, 8'd255);
        send_run(4, 8'd255);
        wait_idle();

        // bottom skip taller than the frame: no row counts
        program_regs(12'd2, 12'd2, 8'd0, 11'd2047, 11'd0, 8'd255);
        send_run(4, 8'd255);
        wait_idle();

        // frame cut short by a new start, a full frame, then a partial one
        // left hanging while the size shrinks under it
        program_regs(12'd3, 12'd2, 8'd0, 11'd0, 11'd2047, 8'd255);
        send_run(4, 8'd255);
        send_run(6, 8'd255);
        send_run(4, 8'd255);
        wait_idle();
        program_regs(12'd1, 12'd1, 8'd0, 11'd0, 11'd2047, 8'd255);
        send_run(2, 8'd255);
        wait_idle();

        // Back-pressure: every pixel closes a frame while the result port
        // is held off, so the block must fill up and stall its input.
        program_regs(12'd1, 12'd1, 8'd0, 11'd0, 11'd0, 8'($urandom_range(255)));
        calm = 1'b1;
        hold_trigger = 1'b1;
        send_frame(60, 1'b1, 20);
        calm = 1'b0;
        wait_idle();
        aligned = 1'b1;

        while (items_sent < ITEM_TARGET) begin
            random_phase();
        end

        calm = 1'b0;
        wait_idle();
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
